// ===== hw/rtl/rgb_fade_cycle_sequencer_defines.svh =====
// assertion helpers used by rgb_fade_cycle_sequencer.sv
`ifndef RGB_FADE_CYCLE_SEQUENCER_DEFINES_SVH
`define RGB_FADE_CYCLE_SEQUENCER_DEFINES_SVH

// condition implies consequence in the same cycle
`define RFCS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rfcs assertion failed");

// condition implies consequence in the next cycle
`define RFCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rfcs assertion failed");

`endif

// ===== hw/rtl/rfcs_pkg.sv =====
`timescale 1ns / 1ps
package rfcs_pkg;

   localparam int LEVEL_W = 16;
   localparam int PHASE_W = 3;
   localparam int CHAN_W = 2;
   localparam int NUM_CHAN = 3;
   localparam int CSR_ADDR_W = 2;

   localparam logic [LEVEL_W-1:0] RAMP_STEP = 16'd3276;
   localparam logic [LEVEL_W-1:0] LEVEL_TOP_RST = 16'd65520;
   localparam logic [LEVEL_W-1:0] PULSE_PEAK_RST = 16'd8192;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_PULSE_MODE = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_LEVEL_TOP = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_PULSE_PEAK = 2'd2;

   // channel codes
   localparam logic [CHAN_W-1:0] CH_RED = 2'd0;
   localparam logic [CHAN_W-1:0] CH_GREEN = 2'd1;
   localparam logic [CHAN_W-1:0] CH_BLUE = 2'd2;

   // phase codes
   localparam logic [PHASE_W-1:0] PH_BLUE_UP = 3'd0;
   localparam logic [PHASE_W-1:0] PH_RED_DOWN = 3'd1;
   localparam logic [PHASE_W-1:0] PH_GREEN_UP = 3'd2;
   localparam logic [PHASE_W-1:0] PH_BLUE_DOWN = 3'd3;
   localparam logic [PHASE_W-1:0] PH_RED_UP = 3'd4;
   localparam logic [PHASE_W-1:0] PH_GREEN_DOWN = 3'd5;
   localparam logic [PHASE_W-1:0] PH_PULSE_RISE = 3'd6;

   typedef struct packed {
      logic                pulse_mode;
      logic [LEVEL_W-1:0]  level_top;
      logic [LEVEL_W-1:0]  pulse_peak;
   } cfg_type;

   typedef struct packed {
      logic [PHASE_W-1:0]               phase;
      logic [NUM_CHAN-1:0][LEVEL_W-1:0] levels;
   } state_type;

   typedef struct packed {
      logic [CHAN_W-1:0]   channel;
      logic [LEVEL_W-1:0]  drive_value;
      logic [PHASE_W-1:0]  phase;
   } result_type;

endpackage

// ===== hw/rtl/rfcs_step.sv =====
`timescale 1ns / 1ps
module rfcs_step (
   input  rfcs_pkg::cfg_type    cfg_i,
   input  rfcs_pkg::state_type  cur_i,
   input  logic                 tick_i,
   output rfcs_pkg::state_type  nxt_o,
   output rfcs_pkg::result_type res_o
);
   import rfcs_pkg::*;

   logic [PHASE_W-1:0] ph;
   logic [CHAN_W-1:0]  ch;
   logic [LEVEL_W-1:0] lvl;
   logic [LEVEL_W:0]   sum;
   logic               up;
   logic               done;
   logic [LEVEL_W-1:0] ramp_lvl;
   logic [LEVEL_W-1:0] cyc_lvl;
   logic [2*LEVEL_W-1:0] sq;
   logic [LEVEL_W:0]   dbl;
   logic [LEVEL_W-1:0] half;

   always_comb begin
      // phase codes above green-down run as the first color phase
      ph = (cur_i.phase <= PH_GREEN_DOWN) ? cur_i.phase : PH_BLUE_UP;
      unique case (ph)
         PH_RED_DOWN, PH_RED_UP:     ch = CH_RED;
         PH_GREEN_UP, PH_GREEN_DOWN: ch = CH_GREEN;
         default:                    ch = CH_BLUE;
      endcase
      lvl = cur_i.levels[ch];
      up = (ph == PH_BLUE_UP) || (ph == PH_GREEN_UP) || (ph == PH_RED_UP);
      sum = {1'b0, lvl} + {1'b0, RAMP_STEP};
      if (up) begin
         done = sum >= {1'b0, cfg_i.level_top};
         ramp_lvl = done ? cfg_i.level_top : sum[LEVEL_W-1:0];
      end else begin
         done = lvl <= RAMP_STEP;
         ramp_lvl = done ? '0 : lvl - RAMP_STEP;
      end
      cyc_lvl = tick_i ? ramp_lvl : lvl;
      sq = cyc_lvl * cyc_lvl;

      dbl = {cur_i.levels[CH_RED], 1'b0};
      half = cur_i.levels[CH_RED] >> 1;

      nxt_o = cur_i;
      res_o.channel = ch;
      res_o.drive_value = sq[2*LEVEL_W-1:LEVEL_W];

      if (cfg_i.pulse_mode) begin
         res_o.channel = CH_RED;
         res_o.drive_value = cur_i.levels[CH_RED];
         if (tick_i) begin
            if (cur_i.phase == PH_PULSE_RISE) begin
               if (dbl >= {1'b0, cfg_i.pulse_peak}) begin
                  nxt_o.levels[CH_RED] = cfg_i.pulse_peak;
                  nxt_o.phase = PH_BLUE_UP;
                  res_o.drive_value = cfg_i.pulse_peak;
               end else begin
                  nxt_o.levels[CH_RED] = dbl[LEVEL_W-1:0];
                  res_o.drive_value = dbl[LEVEL_W-1:0];
               end
            end else begin
               // reporting half the level; once that is zero, restarting the rise from one
               res_o.drive_value = half;
               if (half == '0) begin
                  nxt_o.levels[CH_RED] = LEVEL_W'(1);
                  nxt_o.phase = PH_PULSE_RISE;
               end else begin
                  nxt_o.levels[CH_RED] = half;
                  nxt_o.phase = PH_BLUE_UP;
               end
            end
         end
      end else if (tick_i) begin
         nxt_o.levels[ch] = ramp_lvl;
         if (done) begin
            nxt_o.phase = (ph == PH_GREEN_DOWN) ? PH_BLUE_UP : ph + PHASE_W'(1);
         end else begin
            nxt_o.phase = ph;
         end
      end
      res_o.phase = nxt_o.phase;
   end

endmodule

// ===== hw/rtl/rgb_fade_cycle_sequencer.sv =====
`timescale 1ns / 1ps
`include "rgb_fade_cycle_sequencer_defines.svh"
// RGB fade sequencer: one tick item in, one result item out.
// req channel carries the tick flag; tick 1 steps the fade, tick 0 reports
// the channel and drive value the current phase would update.
// rsp channel carries the drive value and the phase after the step in tdata
// and the channel written (0 red, 1 green, 2 blue) in tuser.
// csr port writes pulse_mode, level_top and pulse_peak; writing pulse_mode
// reloads the channel levels and restarts at phase 0. Write it only while
// no transfer is in flight.
// A req transfer is registered in the input register, then the step logic
// (add/compare and one 16x16 square) feeds the result register that drives
// rsp_tvalid. One item per cycle is sustained while rsp_tready stays high.
// If the rsp side stalls, one item waits in the result register and one in
// the input register before req_tready drops.
// Reset is synchronous: cycle mode, top 65520, peak 8192, red at top,
// green and blue at zero, pipeline empty.
module rgb_fade_cycle_sequencer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [0] tick
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [23:0]                    rsp_tdata,   // [15:0] drive_value, [18:16] phase
   output logic [1:0]                     rsp_tuser,   // [1:0] channel
   input  logic                           csr_we,
   input  logic [rfcs_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [rfcs_pkg::LEVEL_W-1:0]   csr_wdata
);
   import rfcs_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   state_type  state_ff, state_in;
   state_type  step_nxt;
   result_type step_res;
   result_type res_ff, res_in;
   logic       stg_valid_ff, stg_valid_in;
   logic       stg_tick_ff, stg_tick_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       advance;
   logic       req_xfer;

   rfcs_step u_step (
      .cfg_i  (cfg_ff),
      .cur_i  (state_ff),
      .tick_i (stg_tick_ff),
      .nxt_o  (step_nxt),
      .res_o  (step_res)
   );

   assign advance = !rsp_valid_ff || rsp_tready;
   assign req_tready = !stg_valid_ff || advance;
   assign req_xfer = req_tvalid && req_tready;

   always_comb begin
      cfg_in = cfg_ff;
      state_in = state_ff;
      res_in = res_ff;
      stg_tick_in = stg_tick_ff;
      stg_valid_in = stg_valid_ff;
      rsp_valid_in = rsp_valid_ff;

      if (req_xfer) begin
         stg_valid_in = 1'b1;
         stg_tick_in = req_tdata[0];
      end else if (advance) begin
         stg_valid_in = 1'b0;
      end

      if (stg_valid_ff && advance) begin
         state_in = step_nxt;
         res_in = step_res;
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_we) begin
         unique case (csr_addr)
            REG_PULSE_MODE: begin
               cfg_in.pulse_mode = csr_wdata[0];
               state_in.phase = PH_BLUE_UP;
               if (csr_wdata[0]) begin
                  state_in.levels[CH_RED] = cfg_ff.pulse_peak;
                  state_in.levels[CH_GREEN] = LEVEL_W'(1);
                  state_in.levels[CH_BLUE] = LEVEL_W'(1);
               end else begin
                  state_in.levels[CH_RED] = cfg_ff.level_top;
                  state_in.levels[CH_GREEN] = '0;
                  state_in.levels[CH_BLUE] = '0;
               end
            end
            REG_LEVEL_TOP:  cfg_in.level_top = csr_wdata;
            REG_PULSE_PEAK: cfg_in.pulse_peak = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_mode <= 1'b0;
         cfg_ff.level_top <= LEVEL_TOP_RST;
         cfg_ff.pulse_peak <= PULSE_PEAK_RST;
         state_ff.phase <= PH_BLUE_UP;
         state_ff.levels[CH_RED] <= LEVEL_TOP_RST;
         state_ff.levels[CH_GREEN] <= '0;
         state_ff.levels[CH_BLUE] <= '0;
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         state_ff <= state_in;
         stg_valid_ff <= stg_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stg_tick_ff <= stg_tick_in;
      res_ff <= res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {5'b0, res_ff.phase, res_ff.drive_value};
   assign rsp_tuser = res_ff.channel;

   `RFCS_ASSERT_IMPL(a_chan_legal, clock, reset, rsp_tvalid, rsp_tuser != 2'd3)
   `RFCS_ASSERT_IMPL(a_phase_legal, clock, reset, 1'b1, state_ff.phase != 3'd7)
   `RFCS_ASSERT_IMPL(a_pulse_red, clock, reset,
      stg_valid_ff && advance && cfg_ff.pulse_mode, step_res.channel == CH_RED)
   `RFCS_ASSERT_NEXT(a_mode_restart, clock, reset,
      csr_we && (csr_addr == REG_PULSE_MODE), state_ff.phase == PH_BLUE_UP)

endmodule
